// ===== rtl/system_control_coprocessor_regs_assert.svh =====
// assertion helpers for the system control coprocessor block
`ifndef SYSTEM_CONTROL_COPROCESSOR_REGS_ASSERT_SVH
`define SYSTEM_CONTROL_COPROCESSOR_REGS_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scc assertion failed");

// consequent in the cycle after the antecedent
`define SCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scc assertion failed");

`endif

// ===== rtl/scc_pkg.sv =====
package scc_pkg;

    typedef enum logic [3:0] {
        REQ_READ   = 4'd0,
        REQ_WRITE  = 4'd1,
        REQ_COUNT  = 4'd2,
        REQ_INT0   = 4'd3,
        REQ_DMA    = 4'd4,
        REQ_BD     = 4'd5,
        REQ_EIE    = 4'd6,
        REQ_ERL    = 4'd7,
        REQ_EXL    = 4'd8,
        REQ_EXCODE = 4'd9,
        REQ_EPC    = 4'd10
    } scc_req_t;

    localparam logic [4:0] REG_INDEX    = 5'd0;
    localparam logic [4:0] REG_ENTRYLO0 = 5'd2;
    localparam logic [4:0] REG_ENTRYLO1 = 5'd3;
    localparam logic [4:0] REG_PAGEMASK = 5'd5;
    localparam logic [4:0] REG_WIRED    = 5'd6;
    localparam logic [4:0] REG_BADVADDR = 5'd8;
    localparam logic [4:0] REG_COUNT    = 5'd9;
    localparam logic [4:0] REG_ENTRYHI  = 5'd10;
    localparam logic [4:0] REG_COMPARE  = 5'd11;
    localparam logic [4:0] REG_STATUS   = 5'd12;
    localparam logic [4:0] REG_CAUSE    = 5'd13;
    localparam logic [4:0] REG_EPC      = 5'd14;
    localparam logic [4:0] REG_PRID     = 5'd15;
    localparam logic [4:0] REG_CONFIG   = 5'd16;
    localparam logic [4:0] REG_DEBUG    = 5'd23;
    localparam logic [4:0] REG_DEPC     = 5'd24;
    localparam logic [4:0] REG_PERF     = 5'd25;
    localparam logic [4:0] REG_TAGLO    = 5'd28;
    localparam logic [4:0] REG_TAGHI    = 5'd29;
    localparam logic [4:0] REG_ERROREPC = 5'd30;

    localparam logic [7:0]  PRID_IMP   = 8'h2E;
    localparam logic [7:0]  PRID_REV   = 8'h10;
    localparam logic [31:0] PRID_VALUE = {16'h0000, PRID_IMP, PRID_REV};

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 104;

    typedef struct packed {
        logic        int_enable;
        logic        exl_bit;
        logic        erl_bit;
        logic [1:0]  privilege_mode;
        logic        bus_error_mask;
        logic [2:0]  int_mask;
        logic        eie_bit;
        logic        edi_bit;
        logic        cache_hit;
        logic        bev_bit;
        logic        debug_vectors;
        logic [3:0]  cop_usable;
        logic [4:0]  exc_code;
        logic [2:0]  int_pending;
        logic        branch_delay;
        logic [31:0] cycle_count;
        logic [31:0] ret_pc;
        logic [31:0] err_ret_pc;
    } scc_state_t;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [4:0]  reg_index;
        logic [31:0] write_data;
        logic [31:0] count_delta;
        logic        irq_level;
        logic        flag_value;
        logic [4:0]  exception_code;
        logic [31:0] pc_value;
    } scc_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        interrupt_request;
        logic        unhandled_access;
        logic        boot_vectors;
        logic        ei_di_enable;
        logic        error_level;
        logic        exception_level;
        logic [31:0] exception_pc;
        logic [31:0] error_pc;
    } scc_result_t;

    function automatic logic irq_check(input scc_state_t s);
        return s.int_enable & s.eie_bit & ~s.erl_bit & ~s.exl_bit
            & (|(s.int_mask & s.int_pending));
    endfunction

    function automatic logic [31:0] pack_status(input scc_state_t s);
        logic [31:0] d;
        d = '0;
        d[0]     = s.int_enable;
        d[1]     = s.exl_bit;
        d[2]     = s.erl_bit;
        d[4:3]   = s.privilege_mode;
        d[11:10] = s.int_mask[1:0];
        d[12]    = s.bus_error_mask;
        d[15]    = s.int_mask[2];
        d[16]    = s.eie_bit;
        d[17]    = s.edi_bit;
        d[18]    = s.cache_hit;
        d[22]    = s.bev_bit;
        d[23]    = s.debug_vectors;
        d[31:28] = s.cop_usable;
        return d;
    endfunction

    function automatic logic [31:0] pack_cause(input scc_state_t s);
        logic [31:0] d;
        d = '0;
        d[6:2]   = s.exc_code;
        d[11:10] = s.int_pending[1:0];
        d[15]    = s.int_pending[2];
        d[31]    = s.branch_delay;
        return d;
    endfunction

endpackage

// ===== rtl/scc_exec.sv =====
module scc_exec (
    input  scc_pkg::scc_item_t   item,
    input  scc_pkg::scc_state_t  state,
    output scc_pkg::scc_state_t  state_next,
    output scc_pkg::scc_result_t result
);
    import scc_pkg::*;

    scc_req_t    req;
    logic [31:0] rdata;
    logic        irq;
    logic        unh;

    assign req = scc_req_t'(item.req_type);

    always_comb
    begin
        state_next = state;
        rdata      = '0;
        irq        = 1'b0;
        unh        = 1'b0;
        unique case (req)
            REQ_READ:
            begin
                unique case (item.reg_index)
                    REG_BADVADDR, REG_DEBUG, REG_DEPC, REG_PERF, REG_TAGLO, REG_TAGHI:
                        rdata = '0;
                    REG_COUNT:    rdata = state.cycle_count;
                    REG_STATUS:   rdata = pack_status(state);
                    REG_CAUSE:    rdata = pack_cause(state);
                    REG_EPC:      rdata = state.ret_pc;
                    REG_PRID:     rdata = PRID_VALUE;
                    REG_ERROREPC: rdata = state.err_ret_pc;
                    default:      unh = 1'b1;
                endcase
            end
            REQ_WRITE:
            begin
                unique case (item.reg_index)
                    // accepted and dropped, compare interrupt not built
                    REG_INDEX, REG_ENTRYLO0, REG_ENTRYLO1, REG_PAGEMASK, REG_WIRED,
                    REG_ENTRYHI, REG_COMPARE, REG_CONFIG, REG_DEPC, REG_PERF:
                        state_next = state;
                    REG_COUNT: state_next.cycle_count = item.write_data;
                    REG_STATUS:
                    begin
                        state_next.int_enable     = item.write_data[0];
                        state_next.exl_bit        = item.write_data[1];
                        state_next.erl_bit        = item.write_data[2];
                        state_next.privilege_mode = item.write_data[4:3];
                        state_next.int_mask       = {item.write_data[15],
                                                     item.write_data[11:10]};
                        state_next.bus_error_mask = item.write_data[12];
                        state_next.eie_bit        = item.write_data[16];
                        state_next.edi_bit        = item.write_data[17];
                        state_next.cache_hit      = item.write_data[18];
                        state_next.bev_bit        = item.write_data[22];
                        state_next.debug_vectors  = item.write_data[23];
                        state_next.cop_usable     = item.write_data[31:28];
                        irq = irq_check(state_next);
                    end
                    REG_EPC:      state_next.ret_pc     = item.write_data;
                    REG_ERROREPC: state_next.err_ret_pc = item.write_data;
                    default:      unh = 1'b1;
                endcase
            end
            REQ_COUNT: state_next.cycle_count = state.cycle_count + item.count_delta;
            REQ_INT0:
            begin
                state_next.int_pending[0] = item.irq_level;
                irq = irq_check(state_next);
            end
            REQ_DMA:
            begin
                state_next.int_pending[1] = item.irq_level;
                irq = irq_check(state_next);
            end
            REQ_BD: state_next.branch_delay = item.flag_value;
            REQ_EIE:
            begin
                state_next.eie_bit = item.flag_value;
                irq = irq_check(state_next);
            end
            REQ_ERL:
            begin
                state_next.erl_bit = item.flag_value;
                irq = irq_check(state_next);
            end
            REQ_EXL:
            begin
                state_next.exl_bit = item.flag_value;
                irq = irq_check(state_next);
            end
            REQ_EXCODE: state_next.exc_code = item.exception_code;
            REQ_EPC:    state_next.ret_pc   = item.pc_value;
            default:    state_next = state;
        endcase
    end

    assign result.read_data         = rdata;
    assign result.interrupt_request = irq;
    assign result.unhandled_access  = unh;
    assign result.boot_vectors      = state_next.bev_bit;
    assign result.ei_di_enable      = state_next.edi_bit;
    assign result.error_level       = state_next.erl_bit;
    assign result.exception_level   = state_next.exl_bit;
    assign result.exception_pc      = state_next.ret_pc;
    assign result.error_pc          = state_next.err_ret_pc;

endmodule

// ===== rtl/scc_state.sv =====
module scc_state (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  scc_pkg::scc_state_t state_next,
    output scc_pkg::scc_state_t state
);
    import scc_pkg::*;

    scc_state_t state_reg;

    // architected reset values: erl and bev set, everything else zero
    function automatic scc_state_t reset_value();
        scc_state_t s;
        s         = '0;
        s.erl_bit = 1'b1;
        s.bev_bit = 1'b1;
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= reset_value();
        end
        else if (load)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ===== rtl/system_control_coprocessor_regs.sv =====
// system control coprocessor register block
// slave channel (s_*): one access per item, the access kind on s_tuser and
// its operands on s_tdata; an access is taken when s_tvalid and s_tready
// are both high
// master channel (m_*): exactly one result item per access, in order,
// carrying the read value, the interrupt and unhandled flags and a copy of
// bev, edi, erl, exl and both return pcs as they stand after the access
// an access is held in an input register, then is executed in a single
// pass and lands in the output register, which drives m_tvalid; while the
// output register is stalled the access waits in the input register
// throughput is one access per cycle while m_tready does not stall output;
// register state updates as the item moves into the output register, so
// back-to-back accesses see each other
// if m_tready is low the result holds and the input register is still free
// to take one more access; s_tready drops once both stages are full
// reset empties both stages and loads the architected reset values
// (erl and bev set, everything else zero)
module system_control_coprocessor_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // reg_index, write_data, count_delta, irq_level, flag_value,
    // exception_code, pc_value, zero pad
    input  logic [scc_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic [3:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_data, interrupt_request, unhandled_access, boot_vectors,
    // ei_di_enable, error_level, exception_level, exception_pc, error_pc,
    // zero pad
    output logic [scc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import scc_pkg::*;

    logic        in_valid_reg;
    scc_item_t   in_item_reg;
    logic        out_valid_reg;
    scc_result_t out_result_reg;

    scc_item_t   in_item;
    scc_state_t  state;
    scc_state_t  state_next;
    scc_result_t result;
    logic        out_free;
    logic        advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign in_item.req_type       = s_tuser;
    assign in_item.reg_index      = s_tdata[4:0];
    assign in_item.write_data     = s_tdata[36:5];
    assign in_item.count_delta    = s_tdata[68:37];
    assign in_item.irq_level      = s_tdata[69];
    assign in_item.flag_value     = s_tdata[70];
    assign in_item.exception_code = s_tdata[75:71];
    assign in_item.pc_value       = s_tdata[107:76];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    scc_exec u_exec (
        .item       (in_item_reg),
        .state      (state),
        .state_next (state_next),
        .result     (result)
    );

    scc_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .state_next (state_next),
        .state      (state)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_result_reg.error_pc,
                       out_result_reg.exception_pc,
                       out_result_reg.exception_level,
                       out_result_reg.error_level,
                       out_result_reg.ei_di_enable,
                       out_result_reg.boot_vectors,
                       out_result_reg.unhandled_access,
                       out_result_reg.interrupt_request,
                       out_result_reg.read_data};

`include "system_control_coprocessor_regs_assert.svh"

    // state only moves when an access is executed
    `SCC_ASSERT_NEXT(a_state_hold, !advance, $stable(state))
    // an unsupported register gives no data and no interrupt
    `SCC_ASSERT_NOW(a_unh_clean, advance && result.unhandled_access,
        result.read_data == 32'd0 && !result.interrupt_request)
    // an interrupt is never raised while erl or exl is set
    `SCC_ASSERT_NOW(a_irq_levels, advance && result.interrupt_request,
        !state_next.erl_bit && !state_next.exl_bit)
    // a result waiting on a stalled receiver keeps the input side open while the input register is empty
    `SCC_ASSERT_NOW(a_skid_open, out_valid_reg && !m_tready && !in_valid_reg, s_tready)

endmodule

// ===== test/cop0_access_checker.sv =====
`timescale 1ns / 1ps

module cop0_access_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [3:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    output int           mismatches,
    output int           outstanding
);
    import scc_pkg::*;

    typedef struct packed {
        bit        ie;
        bit        exl;
        bit        erl;
        bit [1:0]  ksu;
        bit        bem;
        bit [2:0]  im;
        bit        eie;
        bit        edi;
        bit        ch;
        bit        bev;
        bit        dev;
        bit [3:0]  cu;
        bit [4:0]  excode;
        bit [2:0]  ip;
        bit        bd;
        bit [31:0] count;
        bit [31:0] epc;
        bit [31:0] errorepc;
    } cop0_state_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic        unh;
        logic        bev;
        logic        edi;
        logic        erl;
        logic        exl;
        logic [31:0] epc;
        logic [31:0] errorepc;
    } access_result_t;

    cop0_state_t    cop0;
    access_result_t result_q[$];

    function automatic logic [31:0] status_image();
        return {cop0.cu, 4'b0, cop0.dev, cop0.bev, 3'b0, cop0.ch, cop0.edi, cop0.eie,
                cop0.im[2], 2'b0, cop0.bem, cop0.im[1:0], 5'b0, cop0.ksu, cop0.erl,
                cop0.exl, cop0.ie};
    endfunction

    function automatic logic [31:0] cause_image();
        return {cop0.bd, 15'b0, cop0.ip[2], 3'b0, cop0.ip[1:0], 3'b0, cop0.excode, 2'b0};
    endfunction

    function automatic logic irq_raised();
        return cop0.ie && cop0.eie && !cop0.erl && !cop0.exl && ((cop0.im & cop0.ip) != 0);
    endfunction

    task automatic execute_access(input logic [3:0] req, input logic [111:0] d,
                                  output access_result_t res);
        logic [4:0]  idx;
        logic [31:0] wdata;
        idx   = d[4:0];
        wdata = d[36:5];
        res   = '0;
        case (req)
            REQ_READ:
            begin
                case (idx)
                    REG_BADVADDR, REG_DEBUG, REG_DEPC, REG_PERF, REG_TAGLO, REG_TAGHI:
                        res.rdata = '0;
                    REG_COUNT:    res.rdata = cop0.count;
                    REG_STATUS:   res.rdata = status_image();
                    REG_CAUSE:    res.rdata = cause_image();
                    REG_EPC:      res.rdata = cop0.epc;
                    REG_PRID:     res.rdata = PRID_VALUE;
                    REG_ERROREPC: res.rdata = cop0.errorepc;
                    default:      res.unh = 1'b1;
                endcase
            end
            REQ_WRITE:
            begin
                case (idx)
                    // accepted but dropped, compare included (no timer interrupt)
                    REG_INDEX, REG_ENTRYLO0, REG_ENTRYLO1, REG_PAGEMASK, REG_WIRED,
                    REG_ENTRYHI, REG_COMPARE, REG_CONFIG, REG_DEPC, REG_PERF: ;
                    REG_COUNT: cop0.count = wdata;
                    REG_STATUS:
                    begin
                        cop0.ie  = wdata[0];
                        cop0.exl = wdata[1];
                        cop0.erl = wdata[2];
                        cop0.ksu = wdata[4:3];
                        cop0.im  = {wdata[15], wdata[11:10]};
                        cop0.bem = wdata[12];
                        cop0.eie = wdata[16];
                        cop0.edi = wdata[17];
                        cop0.ch  = wdata[18];
                        cop0.bev = wdata[22];
                        cop0.dev = wdata[23];
                        cop0.cu  = wdata[31:28];
                        res.irq  = irq_raised();
                    end
                    REG_EPC:      cop0.epc = wdata;
                    REG_ERROREPC: cop0.errorepc = wdata;
                    default:      res.unh = 1'b1;
                endcase
            end
            REQ_COUNT: cop0.count = cop0.count + d[68:37];
            REQ_INT0:
            begin
                cop0.ip[0] = d[69];
                res.irq    = irq_raised();
            end
            REQ_DMA:
            begin
                cop0.ip[1] = d[69];
                res.irq    = irq_raised();
            end
            REQ_BD: cop0.bd = d[70];
            REQ_EIE:
            begin
                cop0.eie = d[70];
                res.irq  = irq_raised();
            end
            REQ_ERL:
            begin
                cop0.erl = d[70];
                res.irq  = irq_raised();
            end
            REQ_EXL:
            begin
                cop0.exl = d[70];
                res.irq  = irq_raised();
            end
            REQ_EXCODE: cop0.excode = d[75:71];
            REQ_EPC:    cop0.epc = d[107:76];
            default: ;
        endcase
        res.bev      = cop0.bev;
        res.edi      = cop0.edi;
        res.erl      = cop0.erl;
        res.exl      = cop0.exl;
        res.epc      = cop0.epc;
        res.errorepc = cop0.errorepc;
    endtask

    task automatic compare_field(input string fname, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %h got %h", $time, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t want;
        access_result_t got;
        if (!rst_n)
        begin
            cop0        = '0;
            cop0.erl    = 1'b1;
            cop0.bev    = 1'b1;
            result_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // a result never belongs to an item taken at the same edge
            if (m_tvalid && m_tready)
            begin
                got.rdata    = m_tdata[31:0];
                got.irq      = m_tdata[32];
                got.unh      = m_tdata[33];
                got.bev      = m_tdata[34];
                got.edi      = m_tdata[35];
                got.erl      = m_tdata[36];
                got.exl      = m_tdata[37];
                got.epc      = m_tdata[69:38];
                got.errorepc = m_tdata[101:70];
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with none expected, data %h",
                                 $time, m_tdata);
                end
                else
                begin
                    want = result_q.pop_front();
                    compare_field("read_data", want.rdata, got.rdata);
                    compare_field("interrupt_request", 32'(want.irq), 32'(got.irq));
                    compare_field("unhandled_access", 32'(want.unh), 32'(got.unh));
                    compare_field("boot_vectors", 32'(want.bev), 32'(got.bev));
                    compare_field("ei_di_enable", 32'(want.edi), 32'(got.edi));
                    compare_field("error_level", 32'(want.erl), 32'(got.erl));
                    compare_field("exception_level", 32'(want.exl), 32'(got.exl));
                    compare_field("exception_pc", want.epc, got.epc);
                    compare_field("error_pc", want.errorepc, got.errorepc);
                end
            end
            if (s_tvalid && s_tready)
            begin
                execute_access(s_tuser, s_tdata, want);
                result_q.push_back(want);
            end
            outstanding = result_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import scc_pkg::*;

    // top of the request code space, used for the unknown kinds
    localparam logic [3:0] REQ_TOP_CODE = '1;
    localparam int         HOLD_CYCLES  = 150;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         hold_req = 1'b0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           mismatches;
    int           outstanding;

    always #4 clk = ~clk;

    system_control_coprocessor_regs u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cop0_access_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req <= 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    task automatic send_access(input logic [3:0] req, input logic [4:0] idx,
                               input logic [31:0] wdata, input logic [31:0] delta,
                               input logic lvl, input logic flag,
                               input logic [4:0] ecode, input logic [31:0] pcv);
        s_tuser  <= req;
        s_tdata  <= {4'b0, pcv, ecode, flag, lvl, delta, wdata, idx};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // directed item: one value feeds every operand field except the register index
    task automatic access(input logic [3:0] req, input logic [4:0] idx,
                          input logic [31:0] val);
        send_access(req, idx, val, val, val[0], val[0], val[4:0], val);
    endtask

    task automatic random_access();
        logic [3:0]  req;
        logic [4:0]  idx;
        logic [31:0] wdata;
        int          sel;
        sel = $urandom_range(0, 21);
        if (sel <= 5)
            req = REQ_READ;
        else if (sel <= 10)
            req = REQ_WRITE;
        else if (sel <= 19)
            req = 4'(sel - 11 + int'(REQ_COUNT));
        else
            req = 4'($urandom_range(int'(REQ_EPC) + 1, int'(REQ_TOP_CODE)));
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 14))
                0:       idx = REG_INDEX;
                1:       idx = REG_COMPARE;
                2:       idx = REG_BADVADDR;
                3:       idx = REG_COUNT;
                4:       idx = REG_CAUSE;
                5:       idx = REG_EPC;
                6:       idx = REG_PRID;
                7:       idx = REG_CONFIG;
                8:       idx = REG_DEPC;
                9:       idx = REG_TAGHI;
                10:      idx = REG_ERROREPC;
                default: idx = REG_STATUS;
            endcase
        end
        else begin
            idx = 5'($urandom);
        end
        wdata = $urandom;
        // half the status writes open the interrupt gate so requests can fire
        if (req == REQ_WRITE && idx == REG_STATUS && $urandom_range(0, 1) == 1) begin
            wdata[0]   = 1'b1;
            wdata[2:1] = 2'b00;
            wdata[16]  = 1'b1;
        end
        send_access(req, idx, wdata, $urandom, 1'($urandom), 1'($urandom),
                    5'($urandom), $urandom);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        access(REQ_READ, REG_STATUS, '0);
        access(REQ_READ, REG_CAUSE, '0);
        access(REQ_READ, REG_PRID, '0);
        access(REQ_WRITE, REG_COUNT, '1);
        access(REQ_COUNT, '0, 32'd1);
        access(REQ_READ, REG_COUNT, '0);
        access(REQ_WRITE, REG_STATUS, '1);
        access(REQ_INT0, '0, 32'd1);
        access(REQ_DMA, '0, 32'd1);
        access(REQ_ERL, '0, '0);
        access(REQ_EXL, '0, '0);
        access(REQ_EIE, '0, '0);
        access(REQ_EIE, '0, 32'd1);
        access(REQ_WRITE, REG_COMPARE, '1);
        access(REQ_WRITE, REG_INDEX, '1);
        access(REQ_READ, '1, '0);
        access(REQ_WRITE, REG_CAUSE, '1);
        access(REQ_READ, REG_BADVADDR, '0);
        access(REQ_BD, '0, 32'd1);
        access(REQ_EXCODE, '0, '1);
        access(REQ_READ, REG_CAUSE, '0);
        access(REQ_EPC, '0, '1);
        access(REQ_WRITE, REG_ERROREPC, 32'hA5A5_5A5A);
        access(REQ_READ, REG_ERROREPC, '0);
        access(REQ_READ, REG_EPC, '0);
        access(REQ_TOP_CODE, '1, '1);
        access(REQ_WRITE, REG_STATUS, '0);
        access(REQ_READ, REG_STATUS, '0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_req    <= 1'b1;
                end
                1:
                begin
                    tx_idle_pct  = 58;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 58;
                end
                default:
                begin
                    tx_idle_pct  = 34;
                    rx_stall_pct = 34;
                end
            endcase
            repeat (238) random_access();
        end

        s_tvalid    <= 1'b0;
        rx_stall_pct = 0;
        do @(negedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/scc_pkg.sv
rtl/scc_exec.sv
rtl/scc_state.sv
rtl/system_control_coprocessor_regs.sv
test/cop0_access_checker.sv
test/tb.sv
